[hw/rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion helpers for the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Condition that must never be true outside reset.
`define ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

[hw/rtl/ffba_pkg.sv]
// ----------------------------------------------------------------------------
// ffba_pkg
// Types and constants of the first-fit block allocator.
// ----------------------------------------------------------------------------
package ffba_pkg;

    localparam int ADDR_BITS      = 16;
    localparam int SIZE_BITS      = 16;
    localparam int HEADER_BYTES   = 16;
    localparam int MAX_BLOCKS_DEF = 16;
    localparam int END_BITS       = ADDR_BITS + 1;
    localparam int PADDR_BITS     = 3;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic REG_HEAP_BASE = 1'b0;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_REFUSED = 2'd1,
        ST_UNKNOWN = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH
    } state_t;

    // search token handed from cell to cell
    typedef struct packed {
        logic                 live;
        logic                 found;
        logic [ADDR_BITS-1:0] addr;
        logic [END_BITS-1:0]  last_end;   // msb set: end of last block overflowed
    } tok_t;

endpackage

[hw/rtl/first_fit_block_allocator_top.sv]
// ----------------------------------------------------------------------------
// first_fit_block_allocator_top
// First-fit heap block allocator built as a chain of table cells.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready): cmd, req_size, release_addr. One beat
// is one allocate or free request. Output channel (out_valid/out_ready):
// result_addr and status, exactly one beat per request, in order.
// An allocate of nonzero size or a free of a nonzero address sends a search
// token down the row of MAX_BLOCKS cells, one cell per cycle; the first cell
// that fits (allocate) or matches (free) claims it. Zero size and null free
// skip the search. One request is in flight at a time; the next is taken in
// the cycle after the result is registered.
// The result sits in an output register; a stalled receiver holds it while
// the next request is accepted and searched, and that request waits for
// the register to free before finishing.
// Reset empties the table and clears heap_base; no clearing pass is needed.
// User must write heap_base (APB port, address 0) only while idle; unchecked.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module first_fit_block_allocator_top #(
    parameter int MAX_BLOCKS = ffba_pkg::MAX_BLOCKS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            cmd,
    input  logic [ffba_pkg::SIZE_BITS-1:0]  req_size,
    input  logic [ffba_pkg::ADDR_BITS-1:0]  release_addr,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [ffba_pkg::ADDR_BITS-1:0]  result_addr,
    output logic [1:0]                      status,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [ffba_pkg::PADDR_BITS-1:0] paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);
    import ffba_pkg::*;

    localparam int CW = $clog2(MAX_BLOCKS + 1);
    localparam int SW = ADDR_BITS + 2;

    state_t               state_reg, state_next;
    logic [CW-1:0]        count_reg, count_next;
    logic [ADDR_BITS-1:0] heap_base_reg;
    logic                 cmd_reg;
    logic [SIZE_BITS-1:0] size_reg;
    logic [ADDR_BITS-1:0] rel_reg;
    logic                 launch_reg, launch_next;
    tok_t                 res_reg;
    logic                 out_valid_reg, out_valid_next;
    logic [ADDR_BITS-1:0] result_addr_reg, result_addr_next;
    status_t              status_reg, status_next;

    tok_t                 tok [MAX_BLOCKS+1];
    logic [MAX_BLOCKS-1:0] live_vec;
    logic                 accept;
    logic                 quick;
    logic                 finish;
    logic                 append;
    logic [END_BITS-1:0]  start;
    logic [SW-1:0]        data_sum;
    logic                 load_req;
    logic                 capture;

    assign accept = in_valid && in_ready;
    assign quick  = (cmd == CMD_ALLOC) ? (req_size == '0) : (release_addr == '0);

    assign tok[0] = '{live: launch_reg, found: 1'b0, addr: '0, last_end: '0};

    for (genvar i = 0; i < MAX_BLOCKS; i++)
    begin : g_cell
        ffba_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .is_alloc  (cmd_reg == CMD_ALLOC),
            .req_size  (size_reg),
            .rel_addr  (rel_reg),
            .ent_valid (CW'(i) < count_reg),
            .tok_in    (tok[i]),
            .tok_out   (tok[i+1]),
            .wr_en     (append && (count_reg == CW'(i))),
            .wr_addr   (data_sum[ADDR_BITS-1:0]),
            .wr_size   (size_reg)
        );
        assign live_vec[i] = tok[i+1].live;
    end

    always_comb
    begin
        start = (count_reg == '0) ? END_BITS'(heap_base_reg) : res_reg.last_end;
        data_sum = SW'(start) + SW'(HEADER_BYTES);
    end

    always_comb
    begin
        state_next       = state_reg;
        count_next       = count_reg;
        launch_next      = 1'b0;
        out_valid_next   = out_valid_reg;
        result_addr_next = result_addr_reg;
        status_next      = status_reg;
        in_ready         = 1'b0;
        load_req         = 1'b0;
        capture          = 1'b0;
        finish           = 1'b0;
        append           = 1'b0;

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    load_req    = 1'b1;
                    launch_next = !quick;
                    state_next  = quick ? S_FINISH : S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (tok[MAX_BLOCKS].live)
                begin
                    capture    = 1'b1;
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    finish           = 1'b1;
                    out_valid_next   = 1'b1;
                    result_addr_next = '0;
                    state_next       = S_IDLE;
                    if (cmd_reg == CMD_FREE)
                    begin
                        if (rel_reg == '0 || res_reg.found)
                            status_next = ST_OK;
                        else
                            status_next = ST_UNKNOWN;
                    end
                    else if (size_reg == '0)
                        status_next = ST_REFUSED;
                    else if (res_reg.found)
                    begin
                        status_next      = ST_OK;
                        result_addr_next = res_reg.addr;
                    end
                    else if (count_reg == CW'(MAX_BLOCKS) || start[ADDR_BITS]
                             || data_sum[SW-1:ADDR_BITS] != '0)
                        status_next = ST_REFUSED;
                    else
                    begin
                        append           = 1'b1;
                        count_next       = count_reg + 1'b1;
                        status_next      = ST_OK;
                        result_addr_next = data_sum[ADDR_BITS-1:0];
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            launch_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            heap_base_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            launch_reg    <= launch_next;
            out_valid_reg <= out_valid_next;
            if (psel && penable && pwrite && pready && paddr[2] == REG_HEAP_BASE)
                heap_base_reg <= pwdata[ADDR_BITS-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_req)
        begin
            cmd_reg  <= cmd;
            size_reg <= req_size;
            rel_reg  <= release_addr;
        end
        if (capture)
            res_reg <= tok[MAX_BLOCKS];
        if (finish)
        begin
            result_addr_reg <= result_addr_next;
            status_reg      <= status_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign result_addr = result_addr_reg;
    assign status      = status_reg;
    assign pready      = 1'b1;
    assign prdata      = (paddr[2] == REG_HEAP_BASE) ? 32'(heap_base_reg) : '0;

    `ASSERT_NEVER(a_count_range, count_reg > CW'(MAX_BLOCKS), "entry count above table size")
    `ASSERT_CLK(a_count_only_finish, state_reg != S_FINISH |=> $stable(count_reg), "count moved outside finish")
    `ASSERT_CLK(a_one_token, $onehot0(live_vec), "more than one search token in the chain")
    `ASSERT_CLK(a_out_from_finish, $rose(out_valid_reg) |-> $past(state_reg == S_FINISH), "result without finish")
    `ASSERT_CLK(a_no_accept_busy, accept |=> state_reg != S_IDLE, "request accepted but block stayed idle")

endmodule

[hw/rtl/ffba_cell.sv]
// ----------------------------------------------------------------------------
// ffba_cell
// One table entry: holds address, size and used mark, and updates the
// search token as it passes.
// ----------------------------------------------------------------------------
module ffba_cell (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           is_alloc,
    input  logic [ffba_pkg::SIZE_BITS-1:0] req_size,
    input  logic [ffba_pkg::ADDR_BITS-1:0] rel_addr,
    input  logic                           ent_valid,
    input  ffba_pkg::tok_t                 tok_in,
    output ffba_pkg::tok_t                 tok_out,
    input  logic                           wr_en,
    input  logic [ffba_pkg::ADDR_BITS-1:0] wr_addr,
    input  logic [ffba_pkg::SIZE_BITS-1:0] wr_size
);
    import ffba_pkg::*;

    logic [ADDR_BITS-1:0] addr_reg;
    logic [SIZE_BITS-1:0] size_reg;
    logic                 used_reg;
    tok_t                 tok_reg;
    tok_t                 tok_next;
    logic                 hit;

    always_comb
    begin
        tok_next = tok_in;
        hit      = 1'b0;
        if (tok_in.live && ent_valid)
        begin
            tok_next.last_end = END_BITS'(addr_reg) + END_BITS'(size_reg);
            if (!tok_in.found)
            begin
                if (is_alloc)
                    hit = !used_reg && (size_reg >= req_size);
                else
                    hit = (addr_reg == rel_addr);
            end
        end
        if (hit)
        begin
            tok_next.found = 1'b1;
            tok_next.addr  = addr_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tok_reg <= '0;
        else
            tok_reg <= tok_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            addr_reg <= wr_addr;
            size_reg <= wr_size;
            used_reg <= 1'b1;
        end
        else if (hit)
        begin
            used_reg <= is_alloc;
        end
    end

    assign tok_out = tok_reg;

endmodule
